[rtl/spv_pkg.sv]
// Shared types, constants and the CRC byte step for the status packet validator.
package spv_pkg;

	// Packet geometry
	localparam int unsigned PKT_BYTES = 16;
	localparam int unsigned CRC_SPAN  = 14;
	localparam int unsigned CNT_W     = $clog2(PKT_BYTES + 1);

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Field checks
	localparam logic [15:0] MAGIC_WORD      = 16'hA55A;
	localparam logic [7:0]  STATE_RSVD_MASK = 8'hE0;

	// Result codes
	typedef logic [2:0] result_code_t;
	localparam result_code_t RC_OK       = 3'd0;
	localparam result_code_t RC_SIZE     = 3'd1;
	localparam result_code_t RC_MAGIC    = 3'd2;
	localparam result_code_t RC_VERSION  = 3'd3;
	localparam result_code_t RC_STATE    = 3'd4;
	localparam result_code_t RC_CRC      = 3'd5;
	localparam result_code_t RC_RESERVED = 3'd6;
	localparam result_code_t RC_LENGTH   = 3'd7;

	// Configuration register indexes
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_MAJOR_VERSION = 2'd0;
	localparam cfg_index_t CFG_MIN_LENGTH    = 2'd1;
	localparam cfg_index_t CFG_MAX_LENGTH    = 2'd2;

	localparam logic [7:0]  MAJOR_VERSION_RST = 8'd1;
	localparam logic [31:0] MIN_LENGTH_RST    = 32'd130;
	localparam logic [31:0] MAX_LENGTH_RST    = 32'd65536;

	typedef struct packed {
		logic [7:0]  major_version;
		logic [31:0] min_len;
		logic [31:0] max_len;
	} cfg_t;

	// Packet state gathered as bytes pass
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             overflow;
		logic [15:0]      crc;
		logic [15:0]      magic;
		logic [7:0]       version;
		logic [7:0]       state;
		logic [31:0]      seq_word;
		logic [31:0]      len_word;
		logic [15:0]      reserved;
		logic [15:0]      check;
	} pkt_fields_t;

	typedef struct packed {
		result_code_t code;
		logic [7:0]   version;
		logic [4:0]   link_state;
		logic [31:0]  seq_word;
		logic [31:0]  len_word;
	} result_t;

	// One byte through the CRC, MSB first, eight shift steps
	function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/spv_byte_if.sv]
// Input channel: one packet byte per beat with an end-of-packet flag.
interface spv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       end_of_packet;

	modport source (output valid, output packet_byte, output end_of_packet, input ready);
	modport sink (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

[rtl/spv_result_if.sv]
// Result channel: one verdict per packet.
interface spv_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_code;
	logic [7:0]  version_out;
	logic [4:0]  link_state;
	logic [31:0] frame_sequence;
	logic [31:0] frame_length_out;

	modport source (output valid, output result_code, output version_out, output link_state,
		output frame_sequence, output frame_length_out, input ready);
	modport sink (input valid, input result_code, input version_out, input link_state,
		input frame_sequence, input frame_length_out, output ready);
endinterface

[rtl/spv_cfg_if.sv]
// Configuration write channel: register index and write data.
interface spv_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/spv_cfg_regs.sv]
// Configuration registers: major version and frame length window.
module spv_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	spv_cfg_if.sink       cfg,
	output spv_pkg::cfg_t cfg_val
);

	spv_pkg::cfg_t cfg_q;

	// Writes always taken
	assign cfg.ready = 1'b1;
	assign cfg_val   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.major_version <= spv_pkg::MAJOR_VERSION_RST;
			cfg_q.min_len       <= spv_pkg::MIN_LENGTH_RST;
			cfg_q.max_len       <= spv_pkg::MAX_LENGTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				spv_pkg::CFG_MAJOR_VERSION: cfg_q.major_version <= cfg.data[7:0];
				spv_pkg::CFG_MIN_LENGTH:    cfg_q.min_len       <= cfg.data;
				spv_pkg::CFG_MAX_LENGTH:    cfg_q.max_len       <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/spv_pkt_state.sv]
// Packet state: byte position, running CRC and captured little-endian fields.
module spv_pkt_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 last,
	input  logic [7:0]           data,
	output spv_pkg::pkt_fields_t nxt
);

	spv_pkg::pkt_fields_t cur_q;
	spv_pkg::pkt_fields_t clr;
	logic [3:0]           pos;

	assign pos = cur_q.count[3:0];

	// Empty packet state
	always_comb begin
		clr          = '0;
		clr.crc      = spv_pkg::CRC_INIT;
	end

	// State after the current byte
	always_comb begin
		nxt = cur_q;
		if (cur_q.count < spv_pkg::CNT_W'(spv_pkg::PKT_BYTES)) begin
			nxt.count = cur_q.count + spv_pkg::CNT_W'(1);
			if (pos < 4'(spv_pkg::CRC_SPAN)) begin
				nxt.crc = spv_pkg::crc_byte(cur_q.crc, data);
			end
			case (pos)
				4'd0:  nxt.magic[7:0]      = data;
				4'd1:  nxt.magic[15:8]     = data;
				4'd2:  nxt.version         = data;
				4'd3:  nxt.state           = data;
				4'd4:  nxt.seq_word[7:0]   = data;
				4'd5:  nxt.seq_word[15:8]  = data;
				4'd6:  nxt.seq_word[23:16] = data;
				4'd7:  nxt.seq_word[31:24] = data;
				4'd8:  nxt.len_word[7:0]   = data;
				4'd9:  nxt.len_word[15:8]  = data;
				4'd10: nxt.len_word[23:16] = data;
				4'd11: nxt.len_word[31:24] = data;
				4'd12: nxt.reserved[7:0]   = data;
				4'd13: nxt.reserved[15:8]  = data;
				4'd14: nxt.check[7:0]      = data;
				4'd15: nxt.check[15:8]     = data;
				default: ;
			endcase
		end else begin
			// beyond sixteen bytes: only note the overrun
			nxt.overflow = 1'b1;
		end
	end

	// Clear after the last byte of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= clr;
		end else if (take) begin
			cur_q <= last ? clr : nxt;
		end
	end

endmodule

[rtl/spv_judge.sv]
// Verdict: prioritised checks over the completed packet fields.
module spv_judge (
	input  spv_pkg::pkt_fields_t f,
	input  spv_pkg::cfg_t        cfg_val,
	output spv_pkg::result_t     res
);

	logic bad_size, bad_magic, bad_version, bad_state, bad_crc, bad_rsvd, bad_len;

	assign bad_size    = f.overflow || (f.count != spv_pkg::CNT_W'(spv_pkg::PKT_BYTES));
	assign bad_magic   = f.magic != spv_pkg::MAGIC_WORD;
	assign bad_version = f.version != cfg_val.major_version;
	assign bad_state   = (f.state & spv_pkg::STATE_RSVD_MASK) != 8'h00;
	assign bad_crc     = f.check != f.crc;
	assign bad_rsvd    = f.reserved != 16'h0000;
	assign bad_len     = (f.len_word < cfg_val.min_len) || (f.len_word > cfg_val.max_len);

	always_comb begin
		res = '0;
		if (bad_size) begin
			res.code = spv_pkg::RC_SIZE;
		end else if (bad_magic) begin
			res.code = spv_pkg::RC_MAGIC;
		end else if (bad_version) begin
			res.code = spv_pkg::RC_VERSION;
		end else if (bad_state) begin
			res.code = spv_pkg::RC_STATE;
		end else if (bad_crc) begin
			res.code = spv_pkg::RC_CRC;
		end else if (bad_rsvd) begin
			res.code = spv_pkg::RC_RESERVED;
		end else if (bad_len) begin
			res.code = spv_pkg::RC_LENGTH;
		end else begin
			res.code       = spv_pkg::RC_OK;
			res.version    = f.version;
			res.link_state = f.state[4:0];
			res.seq_word   = f.seq_word;
			res.len_word   = f.len_word;
		end
	end

endmodule

[rtl/status_packet_validator_core.sv]
// Top level of the status packet validator: input register, packet state, verdict register.
// Accepts one packet byte per clock. Each beat lands in an input register and is folded
// into the packet state (CRC-16/CCITT-FALSE over bytes 0-13, field capture) as it leaves
// that register; the beat flagged end_of_packet also loads the result register, so result
// valid rises once the last byte leaves the input register. The input only stalls when an
// end-of-packet byte waits behind a result that has not yet been taken. Configuration
// writes are taken at any time with ready held high and should be issued between packets.
module status_packet_validator_core (
	input logic        clk,
	input logic        arst_n,
	spv_byte_if.sink   packet,
	spv_result_if.source result,
	spv_cfg_if.sink    cfg
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eop_s1;
	logic                 res_valid_q;
	spv_pkg::result_t     res_q;
	spv_pkg::result_t     verdict;
	spv_pkg::pkt_fields_t fields_nxt;
	spv_pkg::cfg_t        cfg_val;
	logic                 out_free;
	logic                 adv;

	spv_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	spv_pkt_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv),
		.last   (eop_s1),
		.data   (byte_s1),
		.nxt    (fields_nxt)
	);

	spv_judge u_judge (
		.f       (fields_nxt),
		.cfg_val (cfg_val),
		.res     (verdict)
	);

	// Flow control: a non-final byte always moves on, a final one needs the result slot
	assign out_free     = !res_valid_q || result.ready;
	assign adv          = valid_s1 && (!eop_s1 || out_free);
	assign packet.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (packet.ready) begin
			valid_s1 <= packet.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (packet.valid && packet.ready) begin
			byte_s1 <= packet.packet_byte;
			eop_s1  <= packet.end_of_packet;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && eop_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eop_s1) begin
			res_q <= verdict;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.result_code      = res_q.code;
	assign result.version_out      = res_q.version;
	assign result.link_state       = res_q.link_state;
	assign result.frame_sequence   = res_q.seq_word;
	assign result.frame_length_out = res_q.len_word;

endmodule

[rtl/spv_checker.sv]
// Port-level checks on the validator's result channel, bound to the top level.
module spv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  result_code,
	input logic [7:0]  version_out,
	input logic [4:0]  link_state,
	input logic [31:0] frame_sequence,
	input logic [31:0] frame_length_out
);

	// Reset empties the result slot
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before accept");

	// A stalled result keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(result_code) && $stable(version_out)
			&& $stable(link_state) && $stable(frame_sequence) && $stable(frame_length_out))
		else $error("result payload changed while stalled");

	// Any failed check zeroes the reported fields
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (result_code != spv_pkg::RC_OK) |-> (version_out == 8'h00)
			&& (link_state == 5'h00) && (frame_sequence == 32'h0)
			&& (frame_length_out == 32'h0))
		else $error("error result carries non-zero fields");

endmodule

bind status_packet_validator_core spv_checker u_spv_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.result_code      (result.result_code),
	.version_out      (result.version_out),
	.link_state       (result.link_state),
	.frame_sequence   (result.frame_sequence),
	.frame_length_out (result.frame_length_out)
);
